@@ src/usan_pkg.sv @@
// ----------------------------------------------------------------------------
// usan_pkg: shared types and constants for the UTF-8 sanitizing stream
// Request structs for both channels, the job descriptor passed from the
// classifier to the emitter, and the byte decode helpers.
// ----------------------------------------------------------------------------
package usan_pkg;

	// Input request: one raw byte of the text
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} item_t;

	// Output request: one byte of the sanitized text
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_last;
		logic       text_valid;
	} result_t;

	// Work for one input byte: r1 replacements, nraw raw bytes, r2 replacements
	typedef struct packed {
		logic [3:0][7:0] raw_bytes;
		logic [2:0]      nraw;
		logic [2:0]      r1;
		logic [1:0]      r2;
		logic [3:0]      len;
		logic            text_end;
		logic            text_ok;
	} job_t;

	localparam int QUEUE_DEPTH = 4;

	// Sequence lengths announced by a lead byte
	localparam logic [2:0] LEN_BAD  = 3'd0;
	localparam logic [2:0] LEN_ONE  = 3'd1;
	localparam logic [2:0] LEN_TWO  = 3'd2;
	localparam logic [2:0] LEN_THR  = 3'd3;
	localparam logic [2:0] LEN_FOUR = 3'd4;

	// U+FFFD encoded
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [1:0] CONT_TAG = 2'b10;

	// Classify a byte met while no sequence is open
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		unique case (b) inside
			[8'h00:8'h7F]: len = LEN_ONE;
			[8'hC2:8'hDF]: len = LEN_TWO;
			[8'hE0:8'hEF]: len = LEN_THR;
			[8'hF0:8'hF4]: len = LEN_FOUR;
			default:       len = LEN_BAD;
		endcase
		return len;
	endfunction

	// Byte of the replacement character at position ph (0..2)
	function automatic logic [7:0] repl_byte(input logic [1:0] ph);
		logic [7:0] v;
		case (ph)
			2'd0:    v = REPL_B0;
			2'd1:    v = REPL_B1;
			default: v = REPL_B2;
		endcase
		return v;
	endfunction

endpackage

@@ src/utf8_sanitize_stream_top.sv @@
// ----------------------------------------------------------------------------
// utf8_sanitize_stream_top: UTF-8 sanitizing byte stream
// Passes well-formed UTF-8 through and replaces malformed or truncated
// sequences with U+FFFD (EF BF BD), flagging whole-text validity at the end.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one raw byte per request, end_of_text on the final byte.
//   result channel : one sanitized byte per request; run_last closes the
//                    bytes caused by one input, text_last closes the text and
//                    carries text_valid.
//   Both channels: a request moves on a rising edge with valid high and
//   stall low.
//   Path: with the emitter idle, a taken input passes the job queue, the
//   emitter job register and the output register; queued jobs wait for the
//   ones ahead. Throughput: one input per cycle while the 4-entry job queue
//   has room; the emitter sends one output byte per cycle when not stalled, so
//   an input costing k result bytes (1 to 12) holds the emitter until all
//   are out. Bytes that only extend a sequence produce no emitter work.
//   Reset clears the open sequence, the queue and the output valid flag.
//   A stalled result holds; the queue then fills and item_stall rises.
// ----------------------------------------------------------------------------
module utf8_sanitize_stream_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  usan_pkg::item_t   item,
	output logic              item_stall,
	output logic              result_valid,
	output usan_pkg::result_t result,
	input  logic              result_stall
);
	import usan_pkg::*;

	job_t push_job;
	job_t q_data;
	logic push;
	logic q_full;
	logic q_valid;
	logic pop;

	// Classifier
	usan_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (push),
		.job        (push_job)
	);

	// Job queue
	usan_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_job),
		.full      (q_full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data)
	);

	// Emitter
	usan_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule

@@ src/usan_front.sv @@
// ----------------------------------------------------------------------------
// usan_front: byte classifier
// Accepts input requests, tracks the open sequence and turns each byte into
// a job descriptor for the emitter. Bytes that only extend a sequence
// produce no job.
// ----------------------------------------------------------------------------
module usan_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  usan_pkg::item_t item,
	output logic           item_stall,
	input  logic           q_full,
	output logic           push,
	output usan_pkg::job_t job
);
	import usan_pkg::*;

	logic [2:0][7:0] held_q;
	logic [1:0]      hcnt_q;
	logic [2:0]      slen_q;
	logic            err_q;

	logic [1:0] hcnt_n;
	logic [2:0] slen_n;
	logic       wr_en;
	logic [1:0] wr_idx;
	logic       fresh;
	logic [2:0] flen;
	logic       is_cont;
	logic       complete;
	logic       rep_any;
	logic       accept;
	logic [4:0] len_w;

	assign is_cont  = (item.in_byte[7:6] == CONT_TAG);
	assign complete = (({1'b0, hcnt_q} + 3'd1) >= slen_q);
	assign flen     = lead_len(item.in_byte);

	// Classify the byte and build the job
	always_comb begin
		job       = '0;
		hcnt_n    = hcnt_q;
		slen_n    = slen_q;
		wr_en     = 1'b0;
		wr_idx    = 2'd0;
		fresh     = 1'b0;
		if (hcnt_q == 2'd0) begin
			fresh = 1'b1;
		end else if (is_cont) begin
			if (complete) begin
				for (int k = 0; k < 3; k++) begin
					job.raw_bytes[k] = (2'(k) < hcnt_q) ? held_q[k] : item.in_byte;
				end
				job.raw_bytes[3] = item.in_byte;
				job.nraw = {1'b0, hcnt_q} + 3'd1;
				hcnt_n   = 2'd0;
				slen_n   = 3'd0;
			end else begin
				wr_en  = 1'b1;
				wr_idx = hcnt_q;
				hcnt_n = hcnt_q + 2'd1;
			end
		end else begin
			// sequence broken: every held byte is replaced
			job.r1 = {1'b0, hcnt_q};
			hcnt_n = 2'd0;
			slen_n = 3'd0;
			fresh  = 1'b1;
		end
		if (fresh) begin
			if (flen == LEN_ONE) begin
				job.raw_bytes[0] = item.in_byte;
				job.nraw         = 3'd1;
			end else if (flen == LEN_BAD) begin
				job.r1 = job.r1 + 3'd1;
			end else begin
				wr_en  = 1'b1;
				wr_idx = 2'd0;
				hcnt_n = 2'd1;
				slen_n = flen;
			end
		end
		// end of text flushes whatever is still held
		if (item.end_of_text) begin
			job.r2 = hcnt_n;
			hcnt_n = 2'd0;
			slen_n = 3'd0;
		end
		len_w        = {1'b0, job.r1, 1'b0} + {2'b00, job.r1} + {2'b00, job.nraw}
			+ {2'b00, job.r2, 1'b0} + {3'b000, job.r2};
		job.len      = len_w[3:0];
		rep_any      = (job.r1 != 3'd0) || (job.r2 != 2'd0);
		job.text_end = item.end_of_text;
		job.text_ok  = !(err_q || rep_any);
	end

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign push       = accept && (job.len != 4'd0);

	// Held bytes: written only when needed, no reset
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[wr_idx] <= item.in_byte;
		end
	end

	// Sequence state and per-text error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hcnt_q <= 2'd0;
			slen_q <= 3'd0;
			err_q  <= 1'b0;
		end else if (accept) begin
			hcnt_q <= hcnt_n;
			slen_q <= slen_n;
			err_q  <= item.end_of_text ? 1'b0 : (err_q || rep_any);
		end
	end

endmodule

@@ src/usan_queue.sv @@
// ----------------------------------------------------------------------------
// usan_queue: job queue
// Small FIFO that decouples the classifier from the emitter. Full is taken
// from the stored count only, so stall on one side never reaches the other
// in the same cycle.
// ----------------------------------------------------------------------------
module usan_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  usan_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           q_valid,
	output usan_pkg::job_t q_data
);
	import usan_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t            mem [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     cnt_q;

	assign full    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_data  = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/usan_back.sv @@
// ----------------------------------------------------------------------------
// usan_back: byte emitter
// Walks one job at a time, one output byte per cycle unless the result is
// stalled: leading replacements, raw bytes, trailing replacements. The next
// job is loaded on the cycle the last byte of the current one goes out.
// ----------------------------------------------------------------------------
module usan_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  usan_pkg::job_t   q_data,
	output logic             pop,
	output logic             result_valid,
	output usan_pkg::result_t result,
	input  logic             result_stall
);
	import usan_pkg::*;

	job_t       job_q;
	logic       busy_q;
	logic [2:0] r1_q;
	logic [1:0] r2_q;
	logic [2:0] raw_left_q;
	logic [1:0] raw_pos_q;
	logic [1:0] ph_q;
	logic [3:0] rem_q;
	logic       out_valid_q;
	result_t    out_q;

	logic       advance;
	logic       last_byte;
	logic [7:0] cur_byte;

	assign advance   = busy_q && (!out_valid_q || !result_stall);
	assign last_byte = (rem_q == 4'd1);
	assign pop       = q_valid && (!busy_q || (advance && last_byte));

	// Pick the byte for the current position
	always_comb begin
		if (r1_q != 3'd0) begin
			cur_byte = repl_byte(ph_q);
		end else if (raw_left_q != 3'd0) begin
			cur_byte = job_q.raw_bytes[raw_pos_q];
		end else begin
			cur_byte = repl_byte(ph_q);
		end
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_data;
		end
	end

	// Sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			r1_q       <= 3'd0;
			r2_q       <= 2'd0;
			raw_left_q <= 3'd0;
			raw_pos_q  <= 2'd0;
			ph_q       <= 2'd0;
			rem_q      <= 4'd0;
		end else if (pop) begin
			busy_q     <= 1'b1;
			r1_q       <= q_data.r1;
			r2_q       <= q_data.r2;
			raw_left_q <= q_data.nraw;
			raw_pos_q  <= 2'd0;
			ph_q       <= 2'd0;
			rem_q      <= q_data.len;
		end else if (advance) begin
			rem_q <= rem_q - 4'd1;
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			if (r1_q != 3'd0 || raw_left_q == 3'd0) begin
				// inside a replacement character
				if (ph_q == 2'd2) begin
					ph_q <= 2'd0;
					if (r1_q != 3'd0) begin
						r1_q <= r1_q - 3'd1;
					end else begin
						r2_q <= r2_q - 2'd1;
					end
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end else begin
				raw_left_q <= raw_left_q - 3'd1;
				raw_pos_q  <= raw_pos_q + 2'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.out_byte   <= cur_byte;
			out_q.run_last   <= last_byte;
			out_q.text_last  <= last_byte && job_q.text_end;
			out_q.text_valid <= last_byte && job_q.text_end && job_q.text_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for utf8_sanitize_stream_top
// Drives byte texts through the item channel and checks every sanitized byte
// against a cycle-free predictor of the UTF-8 cleanup rules. A directed part
// hits the lead class limits, bad leads, broken and truncated sequences. Then
// random texts follow, mostly well-formed characters with some broken ones
// and noise. Random gaps on the item side and random stall on the result side.
// ----------------------------------------------------------------------------
module tb;
	import usan_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_BYTES = 480;
	localparam int MAX_REPORTS  = 30;

	// Directed bytes as {end_of_text, in_byte}
	localparam int N_DIRECTED = 28;
	localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
		// lower limit of every lead class, valid text
		9'h000, 9'h0C2, 9'h080, 9'h0E0, 9'h080, 9'h080,
		9'h0F0, 9'h080, 9'h080, 9'h080, 9'h17F,
		// upper limit of every lead class, valid text
		9'h0DF, 9'h0BF, 9'h0EF, 9'h0BF, 9'h0BF, 9'h0F4, 9'h0BF, 9'h0BF, 9'h1BF,
		// stray continuation, C1, F5, broken lead, sequence cut by the end mark
		9'h080, 9'h0C1, 9'h0F5, 9'h0E0, 9'h041, 9'h0F4, 9'h090, 9'h180
	};

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	item_t   item;
	logic    item_stall;
	logic    result_valid;
	result_t result;
	logic    result_stall;

	int cycle_count = 0;
	int bytes_sent  = 0;
	int texts_sent  = 0;

	// Predicts sanitized bytes per accepted request and checks the output
	class sanitize_board;
		logic [7:0] held [3];
		logic [1:0] held_n;
		logic [2:0] seq_len;
		bit         err_seen;
		result_t    expected_bytes [$];
		result_t    step_bytes [$];
		int         mismatches;
		int         checked;
		int         repl_count;

		function new();
			held_n     = '0;
			seq_len    = '0;
			err_seen   = 1'b0;
			mismatches = 0;
			checked    = 0;
			repl_count = 0;
		endfunction

		function void put_byte(logic [7:0] b);
			result_t r;
			r          = '0;
			r.out_byte = b;
			step_bytes.push_back(r);
		endfunction

		function void put_repl();
			put_byte(REPL_B0);
			put_byte(REPL_B1);
			put_byte(REPL_B2);
			err_seen = 1'b1;
			repl_count++;
		endfunction

		// Every held byte turns into one replacement
		function void drop_held();
			for (int k = 0; k < held_n; k++)
				put_repl();
			held_n  = '0;
			seq_len = '0;
		endfunction

		// Examine a byte with no sequence open
		function void open_seq(logic [7:0] b);
			logic [2:0] len;
			len = '0;
			if (b < 8'h80) begin
				put_byte(b);
				return;
			end
			if (b >= 8'hC2 && b <= 8'hDF)
				len = 3'd2;
			else if (b >= 8'hE0 && b <= 8'hEF)
				len = 3'd3;
			else if (b >= 8'hF0 && b <= 8'hF4)
				len = 3'd4;
			if (len == 3'd0) begin
				put_repl();
				return;
			end
			held[0] = b;
			held_n  = 2'd1;
			seq_len = len;
		endfunction

		function void note_item(item_t it);
			result_t tail;
			step_bytes.delete();
			if (held_n == 2'd0) begin
				open_seq(it.in_byte);
			end else if (it.in_byte[7:6] == CONT_TAG) begin
				if ({1'b0, held_n} + 3'd1 >= seq_len) begin
					for (int k = 0; k < held_n; k++)
						put_byte(held[k]);
					put_byte(it.in_byte);
					held_n  = '0;
					seq_len = '0;
				end else begin
					held[held_n] = it.in_byte;
					held_n       = held_n + 2'd1;
				end
			end else begin
				drop_held();
				open_seq(it.in_byte);
			end

			// End mark flushes what is still held and closes the text
			if (it.end_of_text) begin
				drop_held();
				if (step_bytes.size() > 0) begin
					tail            = step_bytes.pop_back();
					tail.text_last  = 1'b1;
					tail.text_valid = !err_seen;
					step_bytes.push_back(tail);
				end
				err_seen = 1'b0;
			end
			if (step_bytes.size() > 0) begin
				tail          = step_bytes.pop_back();
				tail.run_last = 1'b1;
				step_bytes.push_back(tail);
			end
			foreach (step_bytes[i])
				expected_bytes.push_back(step_bytes[i]);
		endfunction

		task report(string what, result_t got, result_t want);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("MISMATCH %s at output byte %0d: got %h rl%b tl%b tv%b, want %h rl%b tl%b tv%b",
					what, checked, got.out_byte, got.run_last, got.text_last, got.text_valid,
					want.out_byte, want.run_last, want.text_last, want.text_valid);
		endtask

		task check_result(result_t got);
			result_t want;
			checked++;
			if (expected_bytes.size() == 0) begin
				report("unexpected byte", got, '0);
				return;
			end
			want = expected_bytes.pop_front();
			if (got.out_byte !== want.out_byte)
				report("out_byte", got, want);
			if (got.run_last !== want.run_last)
				report("run_last", got, want);
			if (got.text_last !== want.text_last)
				report("text_last", got, want);
			if (got.text_valid !== want.text_valid)
				report("text_valid", got, want);
		endtask

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	sanitize_board sb;

	utf8_sanitize_stream_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item         (item),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// Result side stall: free runs, short stalls, a few long ones
	initial begin
		int pick;
		int span;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				result_stall = 1'b0;
				span         = $urandom_range(1, 30);
			end else if (pick < 90) begin
				result_stall = 1'b1;
				span         = $urandom_range(1, 3);
			end else begin
				result_stall = 1'b1;
				span         = $urandom_range(8, 40);
			end
			repeat (span) @(negedge clk);
		end
	end

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(int len);
		case (len)
			1:       return 8'($urandom_range(8'h00, 8'h7F));
			2:       return 8'($urandom_range(8'hC2, 8'hDF));
			3:       return 8'($urandom_range(8'hE0, 8'hEF));
			default: return 8'($urandom_range(8'hF0, 8'hF4));
		endcase
	endfunction

	// Offer one request after an idle gap; returns at the falling edge after it is taken
	task automatic send_byte(logic [7:0] b, logic eot, int gap);
		if (gap > 0) begin
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid       = 1'b1;
		item.in_byte     = b;
		item.end_of_text = eot;
		do
			@(posedge clk);
		while (item_stall);
		@(negedge clk);
		bytes_sent++;
		if (eot)
			texts_sent++;
	endtask

	// One random text: mostly whole characters, some cut sequences and noise
	task automatic random_text();
		logic [7:0] text_q [$];
		int  nseg;
		int  pick;
		int  len;
		int  keep;
		bit  no_gaps;
		nseg    = $urandom_range(1, 8);
		no_gaps = ($urandom_range(0, 4) == 0);
		for (int s = 0; s < nseg; s++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				len = $urandom_range(1, 4);
				text_q.push_back(lead_byte(len));
				for (int k = 1; k < len; k++)
					text_q.push_back(cont_byte());
			end else if (pick < 78) begin
				len  = $urandom_range(2, 4);
				keep = $urandom_range(0, len - 2);
				text_q.push_back(lead_byte(len));
				for (int k = 0; k < keep; k++)
					text_q.push_back(cont_byte());
			end else if (pick < 90) begin
				text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				case ($urandom_range(0, 2))
					0:       text_q.push_back(cont_byte());
					1:       text_q.push_back(8'hC0 | 8'($urandom_range(0, 1)));
					default: text_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
				endcase
			end
		end
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1, no_gaps ? 0 : pick_gap());
	endtask

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles with %0d output bytes still expected",
			cycle_count, sb.pending());
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		sb         = new();
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i])
			send_byte(DIRECTED[i][7:0], DIRECTED[i][8], pick_gap());
		while (bytes_sent < N_DIRECTED + RANDOM_BYTES)
			random_text();
		item_valid = 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d texts: all lead classes, bad leads, broken and cut sequences.",
			bytes_sent, texts_sent);
		$display("Checked %0d output bytes, %0d replacement characters, %0d mismatches.",
			sb.checked, sb.repl_count, sb.mismatches);
		if (sb.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
